@@ hdl/dgt_pkg.sv @@
// Package for the depth grid triangulator: field widths, register codes,
// reset values, the control flag and face structs, and a depth helper.
// No dependencies.
package dgt_pkg;

    localparam int DEPTH_W    = 16;
    localparam int CORNER_W   = 20;
    localparam int SIZE_W     = 11;
    localparam int LIMIT_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_BITS   = 10;
    localparam int MAX_ROWS   = 1024;

    localparam logic [SIZE_W-1:0]  RESET_ROW_WIDTH    = 11'd640;
    localparam logic [SIZE_W-1:0]  RESET_FRAME_HEIGHT = 11'd480;
    localparam logic [LIMIT_W-1:0] RESET_DEPTH_LIMIT  = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_DEPTH_LIMIT  = 2'd2
    } cfg_reg_t;

    // Position and mask flags of one pixel, handed from the raster counters
    // to the face evaluation stage.
    typedef struct packed {
        logic row_nz;
        logic has_right;
        logic has_left;
        logic left_valid;
        logic pix_valid;
    } pix_flags_t;

    typedef struct packed {
        logic [CORNER_W-1:0] c0;
        logic [CORNER_W-1:0] c1;
        logic [CORNER_W-1:0] c2;
        logic                last;
    } face_t;

    function automatic logic [DEPTH_W-1:0] abs_diff(input logic [DEPTH_W-1:0] a,
                                                    input logic [DEPTH_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ hdl/dgt_pixel_if.sv @@
// Pixel channel: valid/ready handshake carrying a depth and its mask bit.
// Depends on dgt_pkg for the depth width.
interface dgt_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [dgt_pkg::DEPTH_W-1:0] depth_mm;
    logic                        pixel_valid;

    modport source (output valid, output depth_mm, output pixel_valid, input ready);
    modport sink   (input valid, input depth_mm, input pixel_valid, output ready);
endinterface

@@ hdl/dgt_face_if.sv @@
// Face channel: valid/ready handshake carrying three vertex indices and a
// last-of-run mark. Depends on dgt_pkg for the index width.
interface dgt_face_if;
    logic                         valid;
    logic                         ready;
    logic [dgt_pkg::CORNER_W-1:0] corner_zero;
    logic [dgt_pkg::CORNER_W-1:0] corner_one;
    logic [dgt_pkg::CORNER_W-1:0] corner_two;
    logic                         last_of_run;

    modport source (output valid, output corner_zero, output corner_one,
                    output corner_two, output last_of_run, input ready);
    modport sink   (input valid, input corner_zero, input corner_one,
                    input corner_two, input last_of_run, output ready);
endinterface

@@ hdl/dgt_line_buffer.sv @@
// Previous-row line buffer: one write port and two registered read ports.
// No package dependency.
module dgt_line_buffer #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 37,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    // Reads return the old contents when the same entry is written on the
    // same edge.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ hdl/dgt_raster_ctrl.sv @@
// Raster position counters, vertex numbering and the left-neighbor register.
// Depends on dgt_pkg.
module dgt_raster_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int INDEX_BITS = 20,
    localparam int COL_BITS  = $clog2(MAX_WIDTH),
    localparam int WBITS     = $clog2(MAX_WIDTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [dgt_pkg::DEPTH_W-1:0]  depth,
    input  logic                         pix_valid,
    input  logic [dgt_pkg::SIZE_W-1:0]   row_width,
    input  logic [dgt_pkg::SIZE_W-1:0]   frame_height,
    output logic [COL_BITS-1:0]          col,
    output logic [COL_BITS-1:0]          col_right,
    output dgt_pkg::pix_flags_t          flags,
    output logic [INDEX_BITS-1:0]        vert_idx,
    output logic [dgt_pkg::DEPTH_W-1:0]  left_depth,
    output logic [INDEX_BITS-1:0]        left_idx
);
    import dgt_pkg::*;

    logic [COL_BITS-1:0]   col_reg,        col_next;
    logic [ROW_BITS-1:0]   row_reg,        row_next;
    logic [INDEX_BITS-1:0] vcount_reg,     vcount_next;
    logic [DEPTH_W-1:0]    left_depth_reg, left_depth_next;
    logic [INDEX_BITS-1:0] left_idx_reg,   left_idx_next;
    logic                  left_valid_reg, left_valid_next;

    logic [WBITS-1:0]  eff_w;
    logic [SIZE_W-1:0] eff_h;
    logic [WBITS-1:0]  col_inc;
    logic [SIZE_W-1:0] row_inc;
    logic              last_col;
    logic              last_row;

    // Register values out of range saturate.
    always_comb
    begin
        if (row_width < SIZE_W'(2))
            eff_w = WBITS'(2);
        else if (32'(row_width) > 32'(MAX_WIDTH))
            eff_w = WBITS'(MAX_WIDTH);
        else
            eff_w = WBITS'(row_width);

        if (frame_height < SIZE_W'(2))
            eff_h = SIZE_W'(2);
        else if (32'(frame_height) > 32'(MAX_ROWS))
            eff_h = SIZE_W'(MAX_ROWS);
        else
            eff_h = frame_height;
    end

    assign col_inc  = WBITS'(col_reg) + WBITS'(1);
    assign row_inc  = SIZE_W'(row_reg) + SIZE_W'(1);
    assign last_col = (col_inc >= eff_w);
    assign last_row = (row_inc >= eff_h);

    assign col       = col_reg;
    assign col_right = last_col ? col_reg : COL_BITS'(col_inc);
    assign vert_idx  = pix_valid ? vcount_reg : '0;

    assign flags.row_nz     = (row_reg != '0);
    assign flags.has_right  = !last_col;
    assign flags.has_left   = (col_reg != '0);
    assign flags.left_valid = left_valid_reg;
    assign flags.pix_valid  = pix_valid;

    assign left_depth = left_depth_reg;
    assign left_idx   = left_idx_reg;

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        vcount_next     = vcount_reg;
        left_depth_next = left_depth_reg;
        left_idx_next   = left_idx_reg;
        left_valid_next = left_valid_reg;
        if (accept)
        begin
            left_depth_next = depth;
            left_idx_next   = vert_idx;
            left_valid_next = pix_valid;
            if (pix_valid)
                vcount_next = vcount_reg + INDEX_BITS'(1);
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next    = '0;
                    vcount_next = '0;
                end
                else
                begin
                    row_next = ROW_BITS'(row_inc);
                end
            end
            else
            begin
                col_next = COL_BITS'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            vcount_reg     <= '0;
            left_depth_reg <= '0;
            left_idx_reg   <= '0;
            left_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            vcount_reg     <= vcount_next;
            left_depth_reg <= left_depth_next;
            left_idx_reg   <= left_idx_next;
            left_valid_reg <= left_valid_next;
        end
    end

endmodule

@@ hdl/dgt_face_unit.sv @@
// Face evaluation stage and the two-entry result buffer.
// Depends on dgt_pkg; the line buffer read data arrives in the cycle after accept.
module dgt_face_unit #(
    parameter int INDEX_BITS = 20,
    localparam int DATA_W    = dgt_pkg::DEPTH_W + INDEX_BITS + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  dgt_pkg::pix_flags_t          flags,
    input  logic [dgt_pkg::DEPTH_W-1:0]  depth,
    input  logic [INDEX_BITS-1:0]        vert_idx,
    input  logic [dgt_pkg::DEPTH_W-1:0]  left_depth,
    input  logic [INDEX_BITS-1:0]        left_idx,
    input  logic [DATA_W-1:0]            anchor_word,
    input  logic [DATA_W-1:0]            right_word,
    input  logic [dgt_pkg::LIMIT_W-1:0]  limit,
    output logic                         out_valid,
    input  logic                         out_ready,
    output dgt_pkg::face_t               face
);
    import dgt_pkg::*;

    logic                  s1_valid_reg,      s1_valid_next;
    pix_flags_t            s1_flags_reg;
    logic [DEPTH_W-1:0]    s1_depth_reg;
    logic [INDEX_BITS-1:0] s1_idx_reg;
    logic [DEPTH_W-1:0]    s1_left_depth_reg;
    logic [INDEX_BITS-1:0] s1_left_idx_reg;

    face_t head_reg, head_next;
    face_t tail_reg, tail_next;
    logic  head_valid_reg, head_valid_next;
    logic  tail_valid_reg, tail_valid_next;

    logic                  accept;
    logic                  out_fire;
    logic                  buf_free;
    logic                  s1_move;
    logic [DEPTH_W-1:0]    anchor_depth;
    logic [INDEX_BITS-1:0] anchor_idx;
    logic                  anchor_ok;
    logic [DEPTH_W-1:0]    right_depth;
    logic [INDEX_BITS-1:0] right_idx;
    logic                  right_ok;
    logic                  base_ok;
    logic                  hit_a;
    logic                  hit_b;
    face_t                 face_a;
    face_t                 face_b;

    assign out_fire = head_valid_reg && out_ready;
    assign buf_free = !head_valid_reg || (out_ready && !tail_valid_reg);
    assign s1_move  = s1_valid_reg && buf_free;
    assign in_ready = !s1_valid_reg || buf_free;
    assign accept   = in_valid && in_ready;

    assign anchor_depth = anchor_word[DEPTH_W-1:0];
    assign anchor_idx   = anchor_word[DEPTH_W +: INDEX_BITS];
    assign anchor_ok    = anchor_word[DATA_W-1];
    assign right_depth  = right_word[DEPTH_W-1:0];
    assign right_idx    = right_word[DEPTH_W +: INDEX_BITS];
    assign right_ok     = right_word[DATA_W-1];

    // Both faces share the anchor and the downward edge.
    always_comb
    begin
        base_ok = s1_flags_reg.row_nz && s1_flags_reg.pix_valid && anchor_ok &&
                  (abs_diff(anchor_depth, s1_depth_reg) < limit);
        hit_a   = base_ok && s1_flags_reg.has_right && right_ok &&
                  (abs_diff(anchor_depth, right_depth) < limit);
        hit_b   = base_ok && s1_flags_reg.has_left && s1_flags_reg.left_valid &&
                  (abs_diff(anchor_depth, s1_left_depth_reg) < limit);

        face_a.c0   = CORNER_W'(s1_idx_reg);
        face_a.c1   = CORNER_W'(right_idx);
        face_a.c2   = CORNER_W'(anchor_idx);
        face_a.last = !hit_b;

        face_b.c0   = CORNER_W'(s1_left_idx_reg);
        face_b.c1   = CORNER_W'(s1_idx_reg);
        face_b.c2   = CORNER_W'(anchor_idx);
        face_b.last = 1'b1;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        if (out_fire)
        begin
            head_next       = tail_reg;
            head_valid_next = tail_valid_reg;
            tail_valid_next = 1'b0;
        end
        if (s1_move && (hit_a || hit_b))
        begin
            head_next       = hit_a ? face_a : face_b;
            head_valid_next = 1'b1;
            tail_next       = face_b;
            tail_valid_next = hit_a && hit_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg      <= flags;
            s1_depth_reg      <= depth;
            s1_idx_reg        <= vert_idx;
            s1_left_depth_reg <= left_depth;
            s1_left_idx_reg   <= left_idx;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign out_valid = head_valid_reg;
    assign face      = head_reg;

    a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid_reg |-> head_valid_reg)
        else $error("second face buffered without a first");

    a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid_reg |-> tail_reg.last)
        else $error("second face of a pixel not marked last");

    a_open_run_has_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid_reg && !head_reg.last) |-> tail_valid_reg)
        else $error("face run left open with nothing behind it");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel missing from evaluation stage");

endmodule

@@ hdl/depth_grid_triangulator.sv @@
// Top level of the depth grid triangulator: configuration registers, raster
// counters, previous-row line buffer and face evaluation.
// Depends on dgt_pkg, dgt_pixel_if, dgt_face_if and the dgt_* modules.
//
//   Channel   Role    Transaction carries
//   pixels    sink    depth_mm, pixel_valid (one raster-order pixel)
//   faces     source  corner_zero, corner_one, corner_two, last_of_run
//   cfg_*     write   cfg_index selects row_width, frame_height, depth limit
//
// A pixel transaction can be taken every cycle unless the face port stalls
// or two faces wait in the buffer. The pixel is registered in the evaluation
// stage with its line buffer read, then its face in the face register. Two
// faces of one pixel leave one per cycle while faces.ready is high; that port
// sets the sustained rate. Reset clears counters and handshake state; the
// line buffer needs no clearing pass because row 0 of a frame makes no face
// from what it reads. A stalled face port backs up into the evaluation stage
// and then into pixels.ready; no transaction is dropped.
module depth_grid_triangulator #(
    parameter int MAX_WIDTH  = 1024,
    parameter int INDEX_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dgt_pixel_if.sink                       pixels,
    dgt_face_if.source                      faces,
    input  logic                            cfg_we,
    input  logic [dgt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dgt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dgt_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int DATA_W   = DEPTH_W + INDEX_BITS + 1;

    // Configuration registers. The user writes only while idle (unenforced).
    logic [SIZE_W-1:0]  row_width_reg,    row_width_next;
    logic [SIZE_W-1:0]  frame_height_reg, frame_height_next;
    logic [LIMIT_W-1:0] depth_limit_reg,  depth_limit_next;

    always_comb
    begin
        row_width_next    = row_width_reg;
        frame_height_next = frame_height_reg;
        depth_limit_next  = depth_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_WIDTH:    row_width_next    = cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_next = cfg_data[SIZE_W-1:0];
                CFG_DEPTH_LIMIT:  depth_limit_next  = cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= RESET_ROW_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
            depth_limit_reg  <= RESET_DEPTH_LIMIT;
        end
        else
        begin
            row_width_reg    <= row_width_next;
            frame_height_reg <= frame_height_next;
            depth_limit_reg  <= depth_limit_next;
        end
    end

    // The accept strobe drives the counters, the line buffer write of the
    // current column and the reads of the prior row at this column and the
    // next one, or this one again at the last column.
    logic                  accept;
    logic                  in_ready;
    logic [COL_BITS-1:0]   col;
    logic [COL_BITS-1:0]   col_right;
    pix_flags_t            flags;
    logic [INDEX_BITS-1:0] vert_idx;
    logic [DEPTH_W-1:0]    left_depth;
    logic [INDEX_BITS-1:0] left_idx;
    logic [DATA_W-1:0]     anchor_word;
    logic [DATA_W-1:0]     right_word;
    face_t                 face;

    assign accept       = pixels.valid && in_ready;
    assign pixels.ready = in_ready;

    dgt_raster_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .depth        (pixels.depth_mm),
        .pix_valid    (pixels.pixel_valid),
        .row_width    (row_width_reg),
        .frame_height (frame_height_reg),
        .col          (col),
        .col_right    (col_right),
        .flags        (flags),
        .vert_idx     (vert_idx),
        .left_depth   (left_depth),
        .left_idx     (left_idx)
    );

    // Each entry packs the mask bit, the vertex index and the depth.
    dgt_line_buffer #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (DATA_W),
        .ADDR_W (COL_BITS)
    ) u_line_buf (
        .clk     (clk),
        .we      (accept),
        .waddr   (col),
        .wdata   ({pixels.pixel_valid, vert_idx, pixels.depth_mm}),
        .re      (accept),
        .raddr_a (col),
        .raddr_b (col_right),
        .rdata_a (anchor_word),
        .rdata_b (right_word)
    );

    dgt_face_unit #(
        .INDEX_BITS (INDEX_BITS)
    ) u_face (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pixels.valid),
        .in_ready    (in_ready),
        .flags       (flags),
        .depth       (pixels.depth_mm),
        .vert_idx    (vert_idx),
        .left_depth  (left_depth),
        .left_idx    (left_idx),
        .anchor_word (anchor_word),
        .right_word  (right_word),
        .limit       (depth_limit_reg),
        .out_valid   (faces.valid),
        .out_ready   (faces.ready),
        .face        (face)
    );

    assign faces.corner_zero = face.c0;
    assign faces.corner_one  = face.c1;
    assign faces.corner_two  = face.c2;
    assign faces.last_of_run = face.last;

endmodule
